// File: hw/rtl/ffha_pkg.sv
// first-fit heap allocator package: field widths, status and register codes,
// cell commands, controller states and the probe flag bundle
// no dependencies
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS_DEF  = 64;
  localparam int unsigned PAGE_BYTES_DEF  = 4096;
  localparam int unsigned ALIGN_BYTES_DEF = 16;

  localparam int unsigned HDR_BYTES = 48;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned REQ_W     = 27;
  localparam int unsigned MAPPED_W  = 15;
  localparam int unsigned ALN_W     = REQ_W + 1;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [MAPPED_W-1:0] CAP_RESET = 15'd16384;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 4'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 2'd0,
    ST_BAD_SIZE     = 2'd1,
    ST_NO_SPACE     = 2'd2,
    ST_FREE_IGNORED = 2'd3
  } status_e;

  // commands broadcast to the cell row, applied by each cell to its own entry
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SPLIT,
    CMD_TAKE,
    CMD_FREE,
    CMD_MERGE,
    CMD_EXTEND,
    CMD_APPEND
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_PROBE,
    S_SETTLE,
    S_MRG_N,
    S_MRG_P,
    S_PUSH
  } state_e;

  // flags carried by the search probe from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
    logic prev_free;
    logic nseen;
    logic nfree;
    logic fprev;
    logic ffree;
    logic last_free;
  } probe_flags_t;

endpackage

// File: hw/rtl/first_fit_heap_allocator.sv
// first-fit heap allocator top level: controller and the row of table cells
// depends on ffha_pkg and ffha_cell
//
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | mode_i, request_bytes_i, block_address_i
// out     | output    | out_valid_o/out_ready_i | status_o, payload_address_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// each item runs a probe down the cell row, one cell per cycle; an allocate
// launches the probe and, when no free block fits and the heap can grow, extends
// the last free block or appends a new one and searches again; a free of a live
// block marks it free, then merges it with a free next and a free previous block;
// a zero size or an out-of-range free goes straight to the output register
// reset leaves one free block covering the first page; no clearing pass
// a new item is taken while an earlier result still waits in the output register;
// the result of the new item waits until that register is free
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS  = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned PAGE_BYTES  = ffha_pkg::PAGE_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES = ffha_pkg::ALIGN_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [ffha_pkg::REQ_W-1:0]    request_bytes_i,
  input  logic [ffha_pkg::ADDR_W-1:0]   block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffha_pkg::STATUS_W-1:0] status_o,
  output logic [ffha_pkg::ADDR_W-1:0]   payload_address_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ffha_pkg::ADDR_W-1:0]   cfg_data_i
);
  import ffha_pkg::*;

  // page and alignment sizes are powers of two
  localparam int unsigned PAGE_LG = $clog2(PAGE_BYTES);
  localparam int unsigned AL_LG   = $clog2(ALIGN_BYTES);
  localparam int unsigned POS_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned HEAP_W  = MAPPED_W + PAGE_LG;
  localparam int unsigned CW      = ((HEAP_W > ALN_W) ? HEAP_W : ALN_W) + 1;
  localparam int unsigned NEED_W  = ALN_W + 1 - PAGE_LG;
  localparam int unsigned GW      = (NEED_W > MAPPED_W) ? NEED_W : MAPPED_W;
  localparam logic [POS_W:0] FULL = (POS_W+1)'(MAX_BLOCKS);

  state_e state_q, state_d;

  logic                mode_q, mode_d;
  logic [ALN_W-1:0]    aligned_q, aligned_d;
  logic [NEED_W-1:0]   need_q, need_d;
  logic [CW-1:0]       key_q, key_d;
  logic                pass_q, pass_d;
  logic [POS_W:0]      count_q, count_d;
  logic [MAPPED_W-1:0] mapped_q, mapped_d, cap_q, cap_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                nfree_q, nfree_d, fprev_q, fprev_d;
  status_e             res_status_q, res_status_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  cmd_e                cmd_op_q, cmd_op_d;
  logic [POS_W-1:0]    cmd_pos_q, cmd_pos_d;
  logic [HEAP_W-1:0]   cmd_a_q, cmd_a_d, cmd_b_q, cmd_b_d;

  // cell row wiring
  logic              e_v  [MAX_BLOCKS];
  logic              e_fr [MAX_BLOCKS];
  logic [HEAP_W-1:0] e_off[MAX_BLOCKS];
  logic [HEAP_W-1:0] e_sz [MAX_BLOCKS];
  probe_flags_t      pf   [MAX_BLOCKS+1];
  logic [POS_W-1:0]  ppos [MAX_BLOCKS+1];
  logic [HEAP_W-1:0] poff [MAX_BLOCKS+1];
  logic [HEAP_W-1:0] psz  [MAX_BLOCKS+1];

  // probe enters cell 0 in the launch cycle
  always_comb begin
    pf[0]       = '0;
    pf[0].valid = (state_q == S_LAUNCH);
  end
  assign ppos[0] = '0;
  assign poff[0] = '0;
  assign psz[0]  = '0;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic              lv, lf, rv, rf;
    logic [HEAP_W-1:0] lo, ls, ro, rs;
    if (k == 0) begin : g_first
      assign lv = 1'b0;
      assign lf = 1'b0;
      assign lo = '0;
      assign ls = '0;
    end else begin : g_mid
      assign lv = e_v[k-1];
      assign lf = e_fr[k-1];
      assign lo = e_off[k-1];
      assign ls = e_sz[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_last
      assign rv = 1'b0;
      assign rf = 1'b0;
      assign ro = '0;
      assign rs = '0;
    end else begin : g_inner
      assign rv = e_v[k+1];
      assign rf = e_fr[k+1];
      assign ro = e_off[k+1];
      assign rs = e_sz[k+1];
    end

    ffha_cell #(
      .IDX       (k),
      .POS_W     (POS_W),
      .HEAP_W    (HEAP_W),
      .KEY_W     (CW),
      .PAGE_BYTES(PAGE_BYTES)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_op_i    (cmd_op_q),
      .cmd_pos_i   (cmd_pos_q),
      .cmd_a_i     (cmd_a_q),
      .cmd_b_i     (cmd_b_q),
      .probe_mode_i(mode_q),
      .probe_key_i (key_q),
      .l_valid_i   (lv),
      .l_off_i     (lo),
      .l_size_i    (ls),
      .l_free_i    (lf),
      .r_valid_i   (rv),
      .r_off_i     (ro),
      .r_size_i    (rs),
      .r_free_i    (rf),
      .e_valid_o   (e_v[k]),
      .e_off_o     (e_off[k]),
      .e_size_o    (e_sz[k]),
      .e_free_o    (e_fr[k]),
      .pf_i        (pf[k]),
      .ppos_i      (ppos[k]),
      .poff_i      (poff[k]),
      .psize_i     (psz[k]),
      .pf_o        (pf[k+1]),
      .ppos_o      (ppos[k+1]),
      .poff_o      (poff[k+1]),
      .psize_o     (psz[k+1])
    );
  end

  // probe result at the end of the row
  probe_flags_t      tail;
  logic [POS_W-1:0]  tail_pos;
  logic [HEAP_W-1:0] tail_off, tail_sz;
  assign tail     = pf[MAX_BLOCKS];
  assign tail_pos = ppos[MAX_BLOCKS];
  assign tail_off = poff[MAX_BLOCKS];
  assign tail_sz  = psz[MAX_BLOCKS];

  // request decode
  logic              in_fire, cfg_fire, push_ok;
  logic [ALN_W-1:0]  req_sum, aligned_in;
  logic [ADDR_W:0]   lo_lim, hi_lim;
  logic [HEAP_W-1:0] end_off;
  logic              free_bad, req_zero;
  logic [ADDR_W-1:0] addr_rel;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire   = cfg_valid_i;
  assign push_ok    = ~out_valid_q | out_ready_i;

  assign req_zero   = (request_bytes_i == '0);
  assign req_sum    = {1'b0, request_bytes_i} + ALN_W'(ALIGN_BYTES - 1);
  assign aligned_in = {req_sum[ALN_W-1:AL_LG], {AL_LG{1'b0}}};

  assign end_off  = {mapped_q, {PAGE_LG{1'b0}}};
  assign lo_lim   = {1'b0, base_q} + (ADDR_W+1)'(HDR_BYTES);
  assign hi_lim   = {1'b0, base_q} + (ADDR_W+1)'(end_off);
  assign free_bad = ({1'b0, block_address_i} < lo_lim) ||
                    ({1'b0, block_address_i} >= hi_lim) ||
                    (block_address_i[AL_LG-1:0] != '0);
  assign addr_rel = block_address_i - base_q;

  // growth arithmetic
  logic [ALN_W:0]      need_sum;
  logic [GW-1:0]       need_g, room_g;
  logic [HEAP_W-1:0]   added;
  logic                grow_ok, split_ok;
  logic [ADDR_W-1:0]   grant_addr;

  assign need_sum = {1'b0, aligned_q} + (ALN_W+1)'(HDR_BYTES + PAGE_BYTES - 1);
  assign need_g   = GW'(need_q);
  assign room_g   = GW'(cap_q - mapped_q);
  assign added    = {need_g[MAPPED_W-1:0], {PAGE_LG{1'b0}}};
  assign grow_ok  = (mapped_q < cap_q) && (need_g <= room_g) &&
                    (tail.last_free || (count_q < FULL));
  assign split_ok = (CW'(tail_sz) >= (CW'(aligned_q) + CW'(HDR_BYTES + ALIGN_BYTES))) &&
                    (count_q < FULL);
  assign grant_addr = base_q + ADDR_W'(tail_off) + ADDR_W'(HDR_BYTES);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (mode_i ? free_bad : req_zero) state_d = S_PUSH;
          else                               state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: state_d = S_PROBE;
      S_PROBE: begin
        if (tail.valid) begin
          if (!mode_q) begin
            if (tail.found || pass_q || !grow_ok) state_d = S_PUSH;
            else                                   state_d = S_SETTLE;
          end else begin
            if (tail.found && !tail.ffree) state_d = S_MRG_N;
            else                           state_d = S_PUSH;
          end
        end
      end
      S_SETTLE: state_d = S_LAUNCH;
      S_MRG_N:  state_d = S_MRG_P;
      S_MRG_P:  state_d = S_PUSH;
      S_PUSH: begin
        if (push_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and commands
  always_comb begin
    mode_d       = mode_q;
    aligned_d    = aligned_q;
    need_d       = need_q;
    key_d        = key_q;
    pass_d       = pass_q;
    count_d      = count_q;
    mapped_d     = mapped_q;
    cap_d        = cap_q;
    base_d       = base_q;
    pos_d        = pos_q;
    nfree_d      = nfree_q;
    fprev_d      = fprev_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    cmd_op_d     = CMD_NONE;
    cmd_pos_d    = cmd_pos_q;
    cmd_a_d      = cmd_a_q;
    cmd_b_d      = cmd_b_q;

    if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_HEAP_BASE: base_d = cfg_data_i;
        REG_CAPACITY:  cap_d  = cfg_data_i[MAPPED_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d     = mode_i;
          aligned_d  = aligned_in;
          key_d      = mode_i ? CW'(addr_rel[HEAP_W-1:0]) : CW'(aligned_in);
          pass_d     = 1'b0;
          res_addr_d = '0;
          res_status_d = mode_i ? ST_FREE_IGNORED : ST_BAD_SIZE;
        end
      end
      S_LAUNCH: need_d = need_sum[ALN_W:PAGE_LG];
      S_PROBE: begin
        if (tail.valid) begin
          if (!mode_q) begin
            if (tail.found) begin
              // first fit: split off a free tail or hand out the whole block
              res_status_d = ST_DONE;
              res_addr_d   = grant_addr;
              cmd_pos_d    = tail_pos;
              cmd_a_d      = aligned_q[HEAP_W-1:0] & {HEAP_W{1'b1}};
              if (split_ok) begin
                cmd_op_d = CMD_SPLIT;
                count_d  = count_q + 1'b1;
              end else begin
                cmd_op_d = CMD_TAKE;
              end
            end else if (pass_q || !grow_ok) begin
              res_status_d = ST_NO_SPACE;
              res_addr_d   = '0;
            end else begin
              // grow by whole pages, then search again
              pass_d   = 1'b1;
              mapped_d = mapped_q + need_g[MAPPED_W-1:0];
              if (tail.last_free) begin
                cmd_op_d  = CMD_EXTEND;
                cmd_pos_d = POS_W'(count_q - 1'b1);
                cmd_a_d   = added;
              end else begin
                cmd_op_d  = CMD_APPEND;
                cmd_pos_d = count_q[POS_W-1:0];
                cmd_a_d   = end_off;
                cmd_b_d   = added - HEAP_W'(HDR_BYTES);
                count_d   = count_q + 1'b1;
              end
            end
          end else begin
            if (tail.found && !tail.ffree) begin
              cmd_op_d  = CMD_FREE;
              cmd_pos_d = tail_pos;
              pos_d     = tail_pos;
              nfree_d   = tail.nfree;
              fprev_d   = tail.fprev;
            end else begin
              res_status_d = ST_FREE_IGNORED;
              res_addr_d   = '0;
            end
          end
        end
      end
      S_MRG_N: begin
        if (nfree_q) begin
          cmd_op_d  = CMD_MERGE;
          cmd_pos_d = pos_q;
          count_d   = count_q - 1'b1;
        end
      end
      S_MRG_P: begin
        if (fprev_q && (pos_q != '0)) begin
          cmd_op_d  = CMD_MERGE;
          cmd_pos_d = pos_q - 1'b1;
          count_d   = count_q - 1'b1;
        end
        res_status_d = ST_DONE;
        res_addr_d   = '0;
      end
      S_PUSH: begin
        if (push_ok) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= (POS_W+1)'(1);
      mapped_q    <= MAPPED_W'(1);
      cap_q       <= CAP_RESET;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      cmd_op_q    <= CMD_NONE;
      pass_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mapped_q    <= mapped_d;
      cap_q       <= cap_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
      cmd_op_q    <= cmd_op_d;
      pass_q      <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    aligned_q    <= aligned_d;
    need_q       <= need_d;
    key_q        <= key_d;
    pos_q        <= pos_d;
    nfree_q      <= nfree_d;
    fprev_q      <= fprev_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    cmd_pos_q    <= cmd_pos_d;
    cmd_a_q      <= cmd_a_d;
    cmd_b_q      <= cmd_b_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign payload_address_o = out_addr_q;

endmodule

// File: hw/rtl/ffha_cell.sv
// one cell of the block table row: holds one table entry, applies broadcast
// commands with its neighbors' entries, and passes the search probe along
// depends on ffha_pkg
module ffha_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned POS_W      = 6,
  parameter int unsigned HEAP_W     = 27,
  parameter int unsigned KEY_W      = 29,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ffha_pkg::cmd_e        cmd_op_i,
  input  logic [POS_W-1:0]      cmd_pos_i,
  input  logic [HEAP_W-1:0]     cmd_a_i,
  input  logic [HEAP_W-1:0]     cmd_b_i,
  input  logic                  probe_mode_i,
  input  logic [KEY_W-1:0]      probe_key_i,
  input  logic                  l_valid_i,
  input  logic [HEAP_W-1:0]     l_off_i,
  input  logic [HEAP_W-1:0]     l_size_i,
  input  logic                  l_free_i,
  input  logic                  r_valid_i,
  input  logic [HEAP_W-1:0]     r_off_i,
  input  logic [HEAP_W-1:0]     r_size_i,
  input  logic                  r_free_i,
  output logic                  e_valid_o,
  output logic [HEAP_W-1:0]     e_off_o,
  output logic [HEAP_W-1:0]     e_size_o,
  output logic                  e_free_o,
  input  ffha_pkg::probe_flags_t pf_i,
  input  logic [POS_W-1:0]      ppos_i,
  input  logic [HEAP_W-1:0]     poff_i,
  input  logic [HEAP_W-1:0]     psize_i,
  output ffha_pkg::probe_flags_t pf_o,
  output logic [POS_W-1:0]      ppos_o,
  output logic [HEAP_W-1:0]     poff_o,
  output logic [HEAP_W-1:0]     psize_o
);
  import ffha_pkg::*;

  localparam logic [POS_W:0]    MY_POS   = (POS_W+1)'(IDX);
  localparam logic [HEAP_W-1:0] HDR      = HEAP_W'(HDR_BYTES);
  localparam logic [HEAP_W-1:0] INIT_SZ  = HEAP_W'(PAGE_BYTES - HDR_BYTES);

  logic              v_q, v_d, fr_q, fr_d;
  logic [HEAP_W-1:0] off_q, off_d, sz_q, sz_d;
  logic [POS_W:0]    pp, pp1;

  probe_flags_t      pf_q, pf_d;
  logic [POS_W-1:0]  ppos_q, ppos_d;
  logic [HEAP_W-1:0] poff_q, poff_d, psize_q, psize_d;
  logic              fit, match, hit;

  assign pp  = {1'b0, cmd_pos_i};
  assign pp1 = pp + 1'b1;

  always_comb begin
    v_d   = v_q;
    fr_d  = fr_q;
    off_d = off_q;
    sz_d  = sz_q;
    unique case (cmd_op_i)
      CMD_SPLIT: begin
        if (MY_POS == pp) begin
          sz_d = cmd_a_i;
          fr_d = 1'b0;
        end else if (MY_POS == pp1) begin
          // free tail cut from the left neighbor
          v_d   = 1'b1;
          fr_d  = 1'b1;
          off_d = l_off_i + HDR + cmd_a_i;
          sz_d  = l_size_i - cmd_a_i - HDR;
        end else if (MY_POS > pp1) begin
          v_d   = l_valid_i;
          fr_d  = l_free_i;
          off_d = l_off_i;
          sz_d  = l_size_i;
        end
      end
      CMD_TAKE: begin
        if (MY_POS == pp) fr_d = 1'b0;
      end
      CMD_FREE: begin
        if (MY_POS == pp) fr_d = 1'b1;
      end
      CMD_MERGE: begin
        if (MY_POS == pp) begin
          sz_d = sz_q + HDR + r_size_i;
        end else if (MY_POS > pp) begin
          v_d   = r_valid_i;
          fr_d  = r_free_i;
          off_d = r_off_i;
          sz_d  = r_size_i;
        end
      end
      CMD_EXTEND: begin
        if (MY_POS == pp) sz_d = sz_q + cmd_a_i;
      end
      CMD_APPEND: begin
        if (MY_POS == pp) begin
          v_d   = 1'b1;
          fr_d  = 1'b1;
          off_d = cmd_a_i;
          sz_d  = cmd_b_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= (IDX == 0);
      fr_q  <= (IDX == 0);
      off_q <= '0;
      sz_q  <= (IDX == 0) ? INIT_SZ : '0;
    end else begin
      v_q   <= v_d;
      fr_q  <= fr_d;
      off_q <= off_d;
      sz_q  <= sz_d;
    end
  end

  // search probe
  assign fit   = v_q & fr_q & (KEY_W'(sz_q) >= probe_key_i);
  assign match = v_q & ((KEY_W'(off_q) + KEY_W'(HDR_BYTES)) == probe_key_i);
  assign hit   = pf_i.valid & ~pf_i.found & (probe_mode_i ? match : fit);

  always_comb begin
    pf_d    = pf_i;
    ppos_d  = ppos_i;
    poff_d  = poff_i;
    psize_d = psize_i;
    if (hit) begin
      pf_d.found = 1'b1;
      pf_d.fprev = pf_i.prev_free;
      pf_d.ffree = fr_q;
      pf_d.nseen = 1'b0;
      ppos_d     = POS_W'(IDX);
      poff_d     = off_q;
      psize_d    = sz_q;
    end else if (pf_i.found && !pf_i.nseen) begin
      pf_d.nseen = 1'b1;
      pf_d.nfree = v_q & fr_q;
    end
    if (v_q) pf_d.last_free = fr_q;
    pf_d.prev_free = v_q & fr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_q <= '0;
    end else begin
      pf_q <= pf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ppos_q  <= ppos_d;
    poff_q  <= poff_d;
    psize_q <= psize_d;
  end

  assign e_valid_o = v_q;
  assign e_off_o   = off_q;
  assign e_size_o  = sz_q;
  assign e_free_o  = fr_q;
  assign pf_o      = pf_q;
  assign ppos_o    = ppos_q;
  assign poff_o    = poff_q;
  assign psize_o   = psize_q;

endmodule
